>>> src/gcd_pkg.sv
package gcd_pkg;

    // Data path widths
    localparam int XY_W      = 33;   // CORDIC x/y, Q30 with headroom
    localparam int Z_W       = 32;   // CORDIC angle, Q28
    localparam int NUM_LANES = 3;    // lat_a, lat_b, lon difference
    localparam int ATAN_LEN  = 24;
    localparam int DEF_CORDIC_STAGES = 16;

    // Square root: 61-bit radicand, one result bit per step
    localparam int SQ_D_W   = 61;
    localparam int SQ_R_W   = 62;
    localparam int SQ_STEPS = 31;
    localparam int S_W      = 32;    // clamped cosine sum, Q30

    // Angle constants, Q28
    localparam logic signed [Z_W-1:0] ANG_PI      = 32'sd843314857;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 32'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 33'sd652032874;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } rot_lane_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_lane_t;

    typedef struct packed {
        logic [SQ_D_W-1:0]     d;
        logic [SQ_R_W-1:0]     res;
        logic signed [S_W-1:0] s;
    } sqrt_lane_t;

    // Arctangent of 2^-i, Q28
    function automatic logic [Z_W-1:0] atan_q28(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 32'd210828714;
            1:       v = 32'd124459457;
            2:       v = 32'd65760959;
            3:       v = 32'd33381290;
            4:       v = 32'd16755422;
            5:       v = 32'd8385879;
            6:       v = 32'd4193963;
            7:       v = 32'd2097109;
            8:       v = 32'd1048571;
            9:       v = 32'd524287;
            10:      v = 32'd262144;
            11:      v = 32'd131072;
            12:      v = 32'd65536;
            13:      v = 32'd32768;
            14:      v = 32'd16384;
            15:      v = 32'd8192;
            16:      v = 32'd4096;
            17:      v = 32'd2048;
            18:      v = 32'd1024;
            19:      v = 32'd512;
            20:      v = 32'd256;
            21:      v = 32'd128;
            22:      v = 32'd64;
            23:      v = 32'd32;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/gcd_rot_cell.sv
module gcd_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  gcd_pkg::rot_lane_t [gcd_pkg::NUM_LANES-1:0] in_lane,
    output logic                                      out_valid,
    output gcd_pkg::rot_lane_t [gcd_pkg::NUM_LANES-1:0] out_lane
);
    import gcd_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = $signed(atan_q28(STAGE));

    logic                             valid_reg;
    rot_lane_t [NUM_LANES-1:0]        lane_reg;
    rot_lane_t [NUM_LANES-1:0]        lane_next;

    // One rotation step per lane, direction from the residual angle
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_next[i].flip = in_lane[i].flip;
            if (in_lane[i].z >= 0)
            begin
                lane_next[i].x = in_lane[i].x - (in_lane[i].y >>> STAGE);
                lane_next[i].y = in_lane[i].y + (in_lane[i].x >>> STAGE);
                lane_next[i].z = in_lane[i].z - ATAN;
            end
            else
            begin
                lane_next[i].x = in_lane[i].x + (in_lane[i].y >>> STAGE);
                lane_next[i].y = in_lane[i].y - (in_lane[i].x >>> STAGE);
                lane_next[i].z = in_lane[i].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

>>> src/gcd_sqrt_cell.sv
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  gcd_pkg::sqrt_lane_t in_lane,
    output logic                out_valid,
    output gcd_pkg::sqrt_lane_t out_lane
);
    import gcd_pkg::*;

    localparam logic [SQ_R_W-1:0] BITV = SQ_R_W'(1) << (60 - 2 * STEP);

    logic              valid_reg;
    sqrt_lane_t        lane_reg;
    sqrt_lane_t        lane_next;
    logic [SQ_R_W-1:0] trial;

    // One result bit: compare, then subtract or keep
    always_comb
    begin
        trial       = in_lane.res + BITV;
        lane_next.s = in_lane.s;
        if ({1'b0, in_lane.d} >= trial)
        begin
            lane_next.d   = in_lane.d - trial[SQ_D_W-1:0];
            lane_next.res = (in_lane.res >> 1) + BITV;
        end
        else
        begin
            lane_next.d   = in_lane.d;
            lane_next.res = in_lane.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

>>> src/gcd_vec_cell.sv
module gcd_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  gcd_pkg::vec_lane_t in_lane,
    output logic               out_valid,
    output gcd_pkg::vec_lane_t out_lane
);
    import gcd_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = $signed(atan_q28(STAGE));

    logic      valid_reg;
    vec_lane_t lane_reg;
    vec_lane_t lane_next;

    // Drive y toward zero, accumulate the angle turned
    always_comb
    begin
        if (in_lane.y > 0)
        begin
            lane_next.x = in_lane.x + (in_lane.y >>> STAGE);
            lane_next.y = in_lane.y - (in_lane.x >>> STAGE);
            lane_next.z = in_lane.z + ATAN;
        end
        else
        begin
            lane_next.x = in_lane.x - (in_lane.y >>> STAGE);
            lane_next.y = in_lane.y + (in_lane.x >>> STAGE);
            lane_next.z = in_lane.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

>>> src/great_circle_distance.sv
// Channel  Dir  Fields (low bit up)
// s_*      in   lat_a[17:0] lon_a[35:18] lat_b[53:36] lon_b[71:54]
// m_*      out  central_angle[15:0]
//
// One pair is taken per cycle while not frozen; stages, N = min(CORDIC_STAGES, 24):
// three input/reduction stages, N sine/cosine cells, four multiply stages,
// 31 square-root cells, N arccosine cells and the output register.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// A result held at the output with m_tready low freezes the whole pipeline
// and drops s_tready in the same cycle.
module great_circle_distance #(
    parameter int CORDIC_STAGES = gcd_pkg::DEF_CORDIC_STAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // lat_a, lon_a, lat_b, lon_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // central_angle
);
    import gcd_pkg::*;

    localparam int N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    localparam logic signed [34:0] R_PI  = 35'sd843314857;
    localparam logic signed [34:0] R_TWO = 35'sd1686629713;
    localparam logic signed [34:0] R_HALF = 35'sd421657428;
    localparam logic [15:0] RESULT_MAX = 16'd51472;

    logic en;

    // Reduce a Q14 angle to [-pi, pi) in Q28
    function automatic logic signed [34:0] reduce(input logic signed [18:0] v);
        logic signed [34:0] w;
        logic signed [34:0] r;
        w = {{2{v[18]}}, v, 14'b0};
        if (w >= R_PI + 35'sd2 * R_TWO)
            r = w - 35'sd3 * R_TWO;
        else if (w >= R_PI + R_TWO)
            r = w - 35'sd2 * R_TWO;
        else if (w >= R_PI)
            r = w - R_TWO;
        else if (w < -R_PI - 35'sd2 * R_TWO)
            r = w + 35'sd3 * R_TWO;
        else if (w < -R_PI - R_TWO)
            r = w + 35'sd2 * R_TWO;
        else if (w < -R_PI)
            r = w + R_TWO;
        else
            r = w;
        return r;
    endfunction

    // Pipeline advances unless a result is stuck at the output
    assign en       = !(m_tvalid && !m_tready);
    assign s_tready = en;

    // Input stage
    logic                    v0_reg;
    logic signed [18:0]      ang0_reg [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang0_reg[0] <= {s_tdata[17], s_tdata[17:0]};
            ang0_reg[1] <= {s_tdata[53], s_tdata[53:36]};
            ang0_reg[2] <= {s_tdata[35], s_tdata[35:18]} - {s_tdata[71], s_tdata[71:54]};
        end
    end

    // Range reduction stage
    logic               v1_reg;
    logic signed [34:0] red1_reg [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                red1_reg[i] <= reduce(ang0_reg[i]);
        end
    end

    // Fold into [-pi/2, pi/2]; cosine sign kept as flip
    logic                       v2_reg;
    rot_lane_t [NUM_LANES-1:0]  fold2_reg;
    rot_lane_t [NUM_LANES-1:0]  fold2_next;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            fold2_next[i].x = GAIN_Q30;
            fold2_next[i].y = '0;
            if (red1_reg[i] > R_HALF)
            begin
                fold2_next[i].z    = Z_W'(R_PI - red1_reg[i]);
                fold2_next[i].flip = 1'b1;
            end
            else if (red1_reg[i] < -R_HALF)
            begin
                fold2_next[i].z    = Z_W'(-R_PI - red1_reg[i]);
                fold2_next[i].flip = 1'b1;
            end
            else
            begin
                fold2_next[i].z    = Z_W'(red1_reg[i]);
                fold2_next[i].flip = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fold2_reg <= fold2_next;
    end

    // Sine/cosine cells
    logic                      rot_v    [N+1];
    rot_lane_t [NUM_LANES-1:0] rot_lane [N+1];

    assign rot_v[0]    = v2_reg;
    assign rot_lane[0] = fold2_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_rot
        gcd_rot_cell #(.STAGE(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rot_v[g]),
            .in_lane   (rot_lane[g]),
            .out_valid (rot_v[g+1]),
            .out_lane  (rot_lane[g+1])
        );
    end

    // Sine and signed cosine per lane, Q30 in 32 bits
    logic signed [S_W-1:0]  sn  [NUM_LANES];
    logic signed [S_W-1:0]  cs  [NUM_LANES];
    logic signed [XY_W-1:0] cneg [NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            cneg[i] = rot_lane[N][i].flip ? -rot_lane[N][i].x : rot_lane[N][i].x;
            sn[i]   = $signed(rot_lane[N][i].y[S_W-1:0]);
            cs[i]   = $signed(cneg[i][S_W-1:0]);
        end
    end

    // Multiply stage 1: sin*sin and cos*cos
    logic               vm1_reg;
    logic signed [63:0] ss1_reg;
    logic signed [63:0] cc1_reg;
    logic signed [S_W-1:0] cd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm1_reg <= 1'b0;
        else if (en)
            vm1_reg <= rot_v[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss1_reg <= sn[0] * sn[1];
            cc1_reg <= cs[0] * cs[1];
            cd1_reg <= cs[2];
        end
    end

    // Multiply stage 2: times cos of longitude difference
    logic               vm2_reg;
    logic signed [33:0] ss2_reg;
    logic signed [63:0] ccd2_reg;
    logic signed [63:0] cc_sh;
    logic signed [63:0] ss_sh;

    assign cc_sh = cc1_reg >>> 30;
    assign ss_sh = ss1_reg >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm2_reg <= 1'b0;
        else if (en)
            vm2_reg <= vm1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss2_reg  <= $signed(ss_sh[33:0]);
            ccd2_reg <= $signed(cc_sh[S_W-1:0]) * cd1_reg;
        end
    end

    // Stage 3: sum and clamp to [-1, 1]
    logic                  vm3_reg;
    logic signed [S_W-1:0] s3_reg;
    logic signed [63:0]    ccd_sh;
    logic signed [34:0]    sum3;
    logic signed [S_W-1:0] s3_next;

    always_comb
    begin
        ccd_sh = ccd2_reg >>> 30;
        sum3   = 35'(ss2_reg) + 35'($signed(ccd_sh[33:0]));
        if (sum3 > 35'sd1073741824)
            s3_next = 32'sd1073741824;
        else if (sum3 < -35'sd1073741824)
            s3_next = -32'sd1073741824;
        else
            s3_next = S_W'(sum3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm3_reg <= 1'b0;
        else if (en)
            vm3_reg <= vm2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_reg <= s3_next;
    end

    // Stage 4: square of the sum
    logic                  vm4_reg;
    logic signed [63:0]    sq4_reg;
    logic signed [S_W-1:0] s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm4_reg <= 1'b0;
        else if (en)
            vm4_reg <= vm3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq4_reg <= s3_reg * s3_reg;
            s4_reg  <= s3_reg;
        end
    end

    // Square root cells on 1 - s^2
    logic       sq_v    [SQ_STEPS+1];
    sqrt_lane_t sq_lane [SQ_STEPS+1];

    assign sq_v[0]         = vm4_reg;
    assign sq_lane[0].d    = (SQ_D_W'(1) << 60) - sq4_reg[SQ_D_W-1:0];
    assign sq_lane[0].res  = '0;
    assign sq_lane[0].s    = s4_reg;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        gcd_sqrt_cell #(.STEP(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_lane   (sq_lane[g]),
            .out_valid (sq_v[g+1]),
            .out_lane  (sq_lane[g+1])
        );
    end

    // Arccosine cells; negative cosine turned by -90 degrees first
    logic               vec_v    [N+1];
    vec_lane_t          vec_lane [N+1];
    logic signed [XY_W-1:0] t_ext;
    logic signed [XY_W-1:0] s_ext;

    assign t_ext = $signed({2'b00, sq_lane[SQ_STEPS].res[30:0]});
    assign s_ext = XY_W'(sq_lane[SQ_STEPS].s);

    always_comb
    begin
        if (sq_lane[SQ_STEPS].s < 0)
        begin
            vec_lane[0].x = t_ext;
            vec_lane[0].y = -s_ext;
            vec_lane[0].z = ANG_HALF_PI;
        end
        else
        begin
            vec_lane[0].x = s_ext;
            vec_lane[0].y = t_ext;
            vec_lane[0].z = '0;
        end
    end

    assign vec_v[0] = sq_v[SQ_STEPS];

    for (genvar g = 0; g < N; g++)
    begin : g_vec
        gcd_vec_cell #(.STAGE(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vec_v[g]),
            .in_lane   (vec_lane[g]),
            .out_valid (vec_v[g+1]),
            .out_lane  (vec_lane[g+1])
        );
    end

    // Output: clamp at zero, round to Q14, clamp at pi
    logic              out_v_reg;
    logic [15:0]       out_d_reg;
    logic [Z_W-1:0]    zpos;
    logic [Z_W-1:0]    zrnd;
    logic [15:0]       q_next;

    always_comb
    begin
        zpos = (vec_lane[N].z < 0) ? '0 : vec_lane[N].z;
        zrnd = (zpos + Z_W'(8192)) >> 14;
        if (zrnd > Z_W'(RESULT_MAX))
            q_next = RESULT_MAX;
        else
            q_next = zrnd[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vec_v[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_d_reg <= q_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule
